### sv/merge_sort_engine_macros.svh
// Assertion macros for the merge sort engine.
// Included by RTL files that carry concurrent assertions; no other dependencies.
`ifndef MERGE_SORT_ENGINE_MACROS_SVH
`define MERGE_SORT_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
`define MSE_ASSERT(label, clock, rstn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("merge sort engine assertion failed");
`define MSE_ASSERT_NEXT(label, clock, rstn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("merge sort engine assertion failed");
`else
`define MSE_ASSERT(label, clock, rstn, ante, cons)
`define MSE_ASSERT_NEXT(label, clock, rstn, ante, cons)
`endif
`endif

### sv/mse_pkg.sv
// Shared constants and types of the merge sort engine.
// No dependencies.
`default_nettype none
package mse_pkg;
    localparam int MAX_ITEMS = 64;
    localparam int ADDR_W = $clog2(MAX_ITEMS);
    localparam int CNT_W = ADDR_W + 1;
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PRIME,
        ST_MERGE,
        ST_EMIT
    } mse_state_t;
endpackage
`default_nettype wire

### sv/merge_sort_engine.sv
// Top level of the merge sort engine: collection, bottom-up merge passes and output.
// Depends on mse_pkg and merge_sort_engine_macros.svh.
//
// A set of signed words is loaded one word per cycle while busy is low; the word
// flagged last_item closes the set, words beyond MAX_ITEMS are dropped and flagged
// as overflowed. The set of n words is then sorted by ceil(log2 n) merge passes that
// ping-pong between two memories, each pass writing one element per cycle (limited by
// the single write port of the target memory), and is then emitted one word per cycle
// with the strobe high for one cycle each, ascending, equal values in arrival order.
// The receiver cannot stall, so results leave at that rate.
`default_nettype none
`include "merge_sort_engine_macros.svh"
module merge_sort_engine
    import mse_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic signed [DATA_W-1:0] value,
    input  wire logic                     last_item,
    output logic                          strobe,
    output logic signed [DATA_W-1:0]      sorted_value,
    output logic                          last_result,
    output logic                          overflowed
);

    logic [DATA_W-1:0] bank0_mem [MAX_ITEMS];
    logic [DATA_W-1:0] bank1_mem [MAX_ITEMS];

    mse_state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic             src_reg, src_next;
    logic [CNT_W-1:0] width_reg, width_next;
    logic [CNT_W-1:0] a_reg, a_next;
    logic [CNT_W-1:0] b_reg, b_next;
    logic [CNT_W-1:0] mid_reg, mid_next;
    logic [CNT_W-1:0] hi_reg, hi_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic             strobe_reg, strobe_next;
    logic             last_reg, last_next;
    logic             ovf_out_reg, ovf_out_next;

    logic [DATA_W-1:0] rd0a_reg, rd0b_reg, rd1a_reg, rd1b_reg;
    logic [CNT_W-1:0]  rd_addr_a, rd_addr_b;
    logic              we0, we1;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;

    logic              accept;
    logic [DATA_W-1:0] head_a, head_b;
    logic              take_b;
    logic [CNT_W-1:0]  n_new;
    logic [CNT_W:0]    w_dbl, w_quad, hi_plus_w, hi_plus_2w;

    function automatic logic [CNT_W-1:0] clamp_n(input logic [CNT_W:0] x,
                                                 input logic [CNT_W-1:0] n);
        logic [CNT_W:0] n_ext;
        n_ext = {1'b0, n};
        return (x > n_ext) ? n : x[CNT_W-1:0];
    endfunction

    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE) || strobe_reg;
    assign head_a = src_reg ? rd1a_reg : rd0a_reg;
    assign head_b = src_reg ? rd1b_reg : rd0b_reg;
    assign take_b = (a_reg >= mid_reg) ||
                    ((b_reg < hi_reg) && ($signed(head_a) > $signed(head_b)));
    assign n_new  = (count_reg < CNT_W'(MAX_ITEMS)) ? count_reg + 1'b1 : count_reg;
    assign w_dbl      = {1'b0, width_reg} << 1;
    assign w_quad     = w_dbl << 1;
    assign hi_plus_w  = {1'b0, hi_reg} + {1'b0, width_reg};
    assign hi_plus_2w = {1'b0, hi_reg} + w_dbl;

    always_ff @(posedge clk)
    begin
        if (we0)
        begin
            bank0_mem[wr_addr] <= wr_data;
        end
        rd0a_reg <= bank0_mem[rd_addr_a[ADDR_W-1:0]];
        rd0b_reg <= bank0_mem[rd_addr_b[ADDR_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (we1)
        begin
            bank1_mem[wr_addr] <= wr_data;
        end
        rd1a_reg <= bank1_mem[rd_addr_a[ADDR_W-1:0]];
        rd1b_reg <= bank1_mem[rd_addr_b[ADDR_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
            src_reg    <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ovf_reg    <= ovf_next;
            src_reg    <= src_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        width_reg   <= width_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        mid_reg     <= mid_next;
        hi_reg      <= hi_next;
        k_reg       <= k_next;
        last_reg    <= last_next;
        ovf_out_reg <= ovf_out_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        src_next     = src_reg;
        width_next   = width_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        mid_next     = mid_reg;
        hi_next      = hi_reg;
        k_next       = k_reg;
        strobe_next  = 1'b0;
        last_next    = last_reg;
        ovf_out_next = ovf_out_reg;
        rd_addr_a    = a_reg;
        rd_addr_b    = b_reg;
        we0          = 1'b0;
        we1          = 1'b0;
        wr_addr      = count_reg[ADDR_W-1:0];
        wr_data      = value;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (count_reg < CNT_W'(MAX_ITEMS))
                    begin
                        we0 = 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    count_next = n_new;
                    if (last_item)
                    begin
                        src_next   = 1'b0;
                        width_next = CNT_W'(1);
                        a_next     = '0;
                        mid_next   = CNT_W'(1);
                        b_next     = CNT_W'(1);
                        hi_next    = clamp_n((CNT_W + 1)'(2), n_new);
                        k_next     = '0;
                        state_next = (n_new == CNT_W'(1)) ? ST_EMIT : ST_PRIME;
                    end
                end
            end
            ST_PRIME:
            begin
                state_next = ST_MERGE;
            end
            ST_MERGE:
            begin
                wr_addr = k_reg[ADDR_W-1:0];
                wr_data = take_b ? head_b : head_a;
                we0     = src_reg;
                we1     = !src_reg;
                a_next  = take_b ? a_reg : a_reg + 1'b1;
                b_next  = take_b ? b_reg + 1'b1 : b_reg;
                k_next  = k_reg + 1'b1;
                if (k_next == count_reg)
                begin
                    src_next   = !src_reg;
                    width_next = w_dbl[CNT_W-1:0];
                    a_next     = '0;
                    mid_next   = clamp_n(w_dbl, count_reg);
                    b_next     = clamp_n(w_dbl, count_reg);
                    hi_next    = clamp_n(w_quad, count_reg);
                    k_next     = '0;
                    state_next = (w_dbl >= {1'b0, count_reg}) ? ST_EMIT : ST_PRIME;
                end
                else if (k_next == hi_reg)
                begin
                    a_next   = hi_reg;
                    mid_next = clamp_n(hi_plus_w, count_reg);
                    b_next   = clamp_n(hi_plus_w, count_reg);
                    hi_next  = clamp_n(hi_plus_2w, count_reg);
                end
                rd_addr_a = a_next;
                rd_addr_b = b_next;
            end
            ST_EMIT:
            begin
                rd_addr_a    = k_reg;
                strobe_next  = 1'b1;
                last_next    = (k_reg + 1'b1 == count_reg);
                ovf_out_next = ovf_reg;
                k_next       = k_reg + 1'b1;
                if (k_reg + 1'b1 == count_reg)
                begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign strobe       = strobe_reg;
    assign sorted_value = head_a;
    assign last_result  = last_reg;
    assign overflowed   = ovf_out_reg;

    `MSE_ASSERT(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(MAX_ITEMS))
    `MSE_ASSERT(a_merge_in_set, clk, rst_n, state_reg == ST_MERGE, k_reg < count_reg)
    `MSE_ASSERT(a_runs_in_bounds, clk, rst_n, state_reg == ST_MERGE,
                (a_reg <= mid_reg) && (b_reg <= hi_reg) && (hi_reg <= count_reg))
    `MSE_ASSERT_NEXT(a_emit_strobes, clk, rst_n, state_reg == ST_EMIT, strobe)
    `MSE_ASSERT_NEXT(a_last_ends_set, clk, rst_n, strobe && last_result,
                     !strobe && (state_reg == ST_IDLE))

endmodule
`default_nettype wire
